### rtl/oets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and defaults for the odd-even transposition sorter.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int OETS_BLOCK_SIZE  = 16;
  localparam int OETS_VALUE_WIDTH = 32;
  localparam int OETS_DATA_W      = 32;

  // per-cycle operation of the cell row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_EVEN,
    OP_ODD
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_t;

  // controller to datapath / ports
  typedef struct packed {
    cell_op_t op;
    logic     in_stall;
    logic     out_valid;
    logic     out_last;
  } ctrl_t;

endpackage

### rtl/oets_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_cell
// One slot of the sorting row: shifts, or compare-exchanges with a neighbor.
// ----------------------------------------------------------------------------
module oets_cell #(
  parameter int IDX        = 0,
  parameter int BLOCK_SIZE = 16,
  parameter int W          = 32
) (
  input  logic              clk,
  input  oets_pkg::cell_op_t op,
  input  logic [W-1:0]      lower_val,
  input  logic [W-1:0]      upper_val,
  output logic [W-1:0]      val,
  output logic              swap
);
  import oets_pkg::*;

  localparam bit IS_EVEN   = (IDX % 2) == 0;
  localparam bit HAS_LOWER = IDX > 0;
  localparam bit HAS_UPPER = (IDX + 1) < BLOCK_SIZE;

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;
  logic         take_min;   // paired with upper neighbor this rank
  logic         take_max;   // paired with lower neighbor this rank

  always_comb begin
    take_min = 1'b0;
    take_max = 1'b0;
    case (op)
      OP_EVEN: begin
        take_min = IS_EVEN && HAS_UPPER;
        take_max = !IS_EVEN && HAS_LOWER;
      end
      OP_ODD: begin
        take_min = !IS_EVEN && HAS_UPPER;
        take_max = IS_EVEN && HAS_LOWER;
      end
      default: begin
        take_min = 1'b0;
        take_max = 1'b0;
      end
    endcase
  end

  always_comb begin
    val_nxt = val_r;
    swap    = 1'b0;
    if (op == OP_SHIFT) begin
      val_nxt = upper_val;
    end else if (take_min) begin
      if (val_r > upper_val) begin
        val_nxt = upper_val;
        swap    = 1'b1;
      end
    end else if (take_max) begin
      if (lower_val > val_r) begin
        val_nxt = lower_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### rtl/oets_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_ctrl
// Sequencer: load a block, run ranks until a clean pass, drain the block.
// ----------------------------------------------------------------------------
module oets_ctrl #(
  parameter int BLOCK_SIZE = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  input  logic            any_swap,
  output oets_pkg::ctrl_t ctl
);
  import oets_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SIZE - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;      // 0: even rank, 1: odd rank
  logic             pass_swap_r, pass_swap_nxt;

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    pass_swap_nxt = pass_swap_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r == CNT_LAST) begin
            cnt_nxt       = '0;
            state_nxt     = ST_SORT;
            phase_nxt     = 1'b0;
            pass_swap_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SORT: begin
        if (!phase_r) begin
          pass_swap_nxt = any_swap;
          phase_nxt     = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (!(pass_swap_r || any_swap)) begin
            state_nxt = ST_DRAIN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (!out_stall) begin
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.in_stall  = 1'b1;
    ctl.out_valid = 1'b0;
    ctl.out_last  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        ctl.in_stall = 1'b0;
        ctl.op       = in_valid ? OP_SHIFT : OP_HOLD;
      end
      ST_SORT: begin
        ctl.op = phase_r ? OP_ODD : OP_EVEN;
      end
      ST_DRAIN: begin
        ctl.out_valid = 1'b1;
        ctl.out_last  = (cnt_r == CNT_LAST);
        ctl.op        = out_stall ? OP_HOLD : OP_SHIFT;
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      pass_swap_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      pass_swap_r <= pass_swap_nxt;
    end
  end

endmodule

### rtl/odd_even_transposition_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// Block sorter: loads BLOCK_SIZE values, sorts them ascending in a row of
// compare-exchange cells, then streams them out with a last marker.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | in_data_value
//  out     | output    | out_valid/out_stall| out_sorted_value, out_is_last
//
//  Sequence: load one value per transfer, then run ranks (one even or odd
//  rank per cycle, stops after a full pass with no exchange), then drain one
//  value per transfer. A new block loads only after the drain ends.
//  The number of ranks depends on the data in the block.
//  Reset: rst_n synchronous active low clears the sequencer only; cell
//  contents are not reset and are always loaded before they are read.
//  Stalls: in_stall is high while sorting and draining; out_stall freezes the
//  drain shift, holding out_sorted_value and out_is_last steady.
//
module odd_even_transposition_sorter #(
  parameter int BLOCK_SIZE  = oets_pkg::OETS_BLOCK_SIZE,
  parameter int VALUE_WIDTH = oets_pkg::OETS_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [oets_pkg::OETS_DATA_W-1:0] in_data_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [oets_pkg::OETS_DATA_W-1:0] out_sorted_value,
  output logic                            out_is_last
);
  import oets_pkg::*;

  // stored width: values are truncated to the smaller of VALUE_WIDTH and the port width
  localparam int CELL_W = (VALUE_WIDTH < OETS_DATA_W) ? VALUE_WIDTH : OETS_DATA_W;

  ctrl_t               ctl;
  logic [CELL_W-1:0]   cell_val  [BLOCK_SIZE];
  logic [BLOCK_SIZE-1:0] swap_vec;
  logic                any_swap;

  assign any_swap = |swap_vec;

  oets_ctrl #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .any_swap  (any_swap),
    .ctl       (ctl)
  );

  // Cell row. Values shift toward cell 0 on load and drain: new input enters
  // at the top cell, results leave from cell 0. Each rank pairs neighbors,
  // lower cell keeps the min, upper cell keeps the max.
  for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
    logic [CELL_W-1:0] lower_v;
    logic [CELL_W-1:0] upper_v;

    if (i == 0) begin : g_bottom
      assign lower_v = cell_val[0];      // no lower neighbor; never selected
    end else begin : g_lower
      assign lower_v = cell_val[i-1];
    end

    if (i == BLOCK_SIZE - 1) begin : g_top
      assign upper_v = in_data_value[CELL_W-1:0];
    end else begin : g_upper
      assign upper_v = cell_val[i+1];
    end

    oets_cell #(
      .IDX        (i),
      .BLOCK_SIZE (BLOCK_SIZE),
      .W          (CELL_W)
    ) u_cell (
      .clk       (clk),
      .op        (ctl.op),
      .lower_val (lower_v),
      .upper_val (upper_v),
      .val       (cell_val[i]),
      .swap      (swap_vec[i])
    );
  end

  assign in_stall         = ctl.in_stall;
  assign out_valid        = ctl.out_valid;
  assign out_is_last      = ctl.out_last;
  assign out_sorted_value = OETS_DATA_W'(cell_val[0]);

`ifndef ASSERT_OFF
  // last marker only rides on a valid result
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_last |-> out_valid)
    else $error("out_is_last without out_valid");

  // drain ends with the last transfer
  a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_is_last) |=> !out_valid)
    else $error("results continue past the last transfer");

  // no loading while results are pending
  a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input open while draining");

  // cell row never exchanges while loading or draining
  a_swap_only_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_SHIFT || ctl.op == OP_HOLD) |-> !any_swap)
    else $error("exchange outside a rank cycle");
`endif

endmodule
